// ----- hdl/cutoff_tanimoto_similarity_unit_defines.svh -----
// Assertion macros shared by the similarity unit modules.
`ifndef CUTOFF_TANIMOTO_SIMILARITY_UNIT_DEFINES_SVH
`define CUTOFF_TANIMOTO_SIMILARITY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge out of reset.
`define CTSU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CTSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CTSU_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CTSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/ctsu_pkg.sv -----
`default_nettype none

package ctsu_pkg;

    // Saturation bound of both feature counts.
    localparam int MAX_FEATURES = 1024;

    // Field widths of the stream payload.
    localparam int VALUE_W  = 32;
    localparam int CUT_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int SCORE_W  = FRAC_W + 1;
    localparam int IN_DATA_W  = ((2 * VALUE_W + CUT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SCORE_W + 7) / 8) * 8;

    // Counter, denominator, dividend and step widths.
    localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
    localparam int DEN_W  = CNT_W + 1;
    localparam int DVD_W  = CNT_W + FRAC_W;
    localparam int STEP_W = $clog2(DVD_W);

    // Difference of two values, and its compare width.
    localparam int DIFF_W = VALUE_W + 1;
    localparam int CMP_W  = VALUE_W + 2;

    // Pair queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_MODE = 1'b0;

    // Similarity modes.
    localparam logic MODE_OVER_PRESENT = 1'b0;
    localparam logic MODE_TANIMOTO     = 1'b1;

    // Counts of one finished vector pair.
    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] shared_cnt;
        logic [CNT_W-1:0] present_cnt;
    } pair_t;

    // Saturating count increment.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_FEATURES);
        return (c < lim) ? c + 1'b1 : lim;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ctsu_front.sv -----
`default_nettype none

`include "cutoff_tanimoto_similarity_unit_defines.svh"

module ctsu_front
    import ctsu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] value_a,
    input  wire logic [VALUE_W-1:0] value_b,
    input  wire logic [CUT_W-1:0]   cutoff,
    input  wire logic               last_feature,
    input  wire logic               mode,
    input  wire logic               q_full,
    output logic                    q_push,
    output pair_t                   q_push_data
);

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic                     s1_present_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic [CUT_W-1:0]         s1_cut_reg;
    logic [CNT_W-1:0]         shared_reg, shared_next;
    logic [CNT_W-1:0]         present_reg, present_next;

    logic                     in_fire;
    logic                     s1_fire;
    logic                     present_in;
    logic signed [DIFF_W-1:0] diff_in;
    logic signed [CMP_W-1:0]  diff_ext;
    logic signed [CMP_W-1:0]  cut_pos;
    logic signed [CMP_W-1:0]  cut_neg;
    logic                     shared_hit;
    logic [CNT_W-1:0]         shared_upd;
    logic [CNT_W-1:0]         present_upd;

    // Stage 0: presence test and signed difference.
    always_comb
    begin
        present_in = (value_a != '0) || (value_b != '0);
        diff_in    = DIFF_W'($signed(value_a)) - DIFF_W'($signed(value_b));
    end

    // The stage holds only when a pair ends and the queue has no room.
    assign s1_fire  = s1_valid_reg && !(s1_last_reg && q_full);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_last_reg    <= last_feature;
            s1_present_reg <= present_in;
            s1_diff_reg    <= diff_in;
            s1_cut_reg     <= cutoff;
        end
    end

    // Stage 1: |a - b| < cutoff is the same as -cutoff < a - b < cutoff.
    always_comb
    begin
        diff_ext   = CMP_W'(s1_diff_reg);
        cut_pos    = $signed({{(CMP_W - CUT_W){1'b0}}, s1_cut_reg});
        cut_neg    = -cut_pos;
        shared_hit = s1_present_reg && (diff_ext < cut_pos) && (diff_ext > cut_neg);
    end

    // Count update; a pair's counts leave on its last feature.
    always_comb
    begin
        present_upd  = s1_present_reg ? sat_inc(present_reg) : present_reg;
        shared_upd   = shared_hit ? sat_inc(shared_reg) : shared_reg;
        present_next = present_reg;
        shared_next  = shared_reg;
        if (s1_fire)
        begin
            present_next = s1_last_reg ? '0 : present_upd;
            shared_next  = s1_last_reg ? '0 : shared_upd;
        end
    end

    assign q_push                  = s1_fire && s1_last_reg;
    assign q_push_data.mode        = mode;
    assign q_push_data.shared_cnt  = shared_upd;
    assign q_push_data.present_cnt = present_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_reg  <= '0;
            present_reg <= '0;
        end
        else
        begin
            shared_reg  <= shared_next;
            present_reg <= present_next;
        end
    end

    `CTSU_ASSERT_ALWAYS(a_shared_le_present, clk, rst_n, shared_reg <= present_reg)
    `CTSU_ASSERT_IMPLIES(a_push_not_full, clk, rst_n, q_push, !q_full)
    `CTSU_ASSERT_NEXT(a_counts_clear, clk, rst_n, q_push, (shared_reg == '0) && (present_reg == '0))

endmodule

`default_nettype wire

// ----- hdl/ctsu_queue.sv -----
`default_nettype none

module ctsu_queue
    import ctsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pair_t push_data,
    output logic       full,
    input  wire logic  pop,
    output pair_t      pop_data,
    output logic       empty
);

    pair_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ctsu_back.sv -----
`default_nettype none

`include "cutoff_tanimoto_similarity_unit_defines.svh"

module ctsu_back
    import ctsu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire pair_t               q_pop_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SCORE_W-1:0]       score,
    output logic                     empty_pair
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               empty_reg;
    logic               out_valid_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               empty_pair_reg;

    logic [DEN_W-1:0]   den_in;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_diff;
    logic               q_bit;
    logic [DEN_W-1:0]   rem_next;
    logic [DVD_W-1:0]   dvd_next;
    logic               out_free;

    // Denominator of the popped pair.
    always_comb
    begin
        if (q_pop_data.mode == MODE_TANIMOTO)
        begin
            den_in = {q_pop_data.present_cnt, 1'b0} - {1'b0, q_pop_data.shared_cnt};
        end
        else
        begin
            den_in = {1'b0, q_pop_data.present_cnt};
        end
    end

    // One restoring division step; the quotient shifts into the dividend.
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        rem_next = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer with the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            score_reg      <= '0;
            empty_pair_reg <= 1'b0;
        end
        else
        begin
            // A new result replaces a taken one; otherwise a taken result leaves.
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= (q_pop_data.present_cnt == '0) ? ST_FINISH : ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (step_reg == STEP_W'(DVD_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        score_reg      <= dvd_reg[SCORE_W-1:0];
                        empty_pair_reg <= empty_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Division datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                dvd_reg   <= (q_pop_data.present_cnt == '0)
                           ? '0 : {q_pop_data.shared_cnt, {FRAC_W{1'b0}}};
                den_reg   <= den_in;
                rem_reg   <= '0;
                step_reg  <= '0;
                empty_reg <= (q_pop_data.present_cnt == '0);
            end
            ST_DIVIDE:
            begin
                dvd_reg  <= dvd_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign score      = score_reg;
    assign empty_pair = empty_pair_reg;

    `CTSU_ASSERT_IMPLIES(a_den_nonzero, clk, rst_n, state_reg == ST_DIVIDE, den_reg != '0)
    `CTSU_ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid_reg && empty_pair_reg, score_reg == '0)
    `CTSU_ASSERT_IMPLIES(a_score_range, clk, rst_n, out_valid_reg, score_reg <= SCORE_W'(1 << FRAC_W))

endmodule

`default_nettype wire

// ----- hdl/cutoff_tanimoto_similarity_unit.sv -----
`default_nettype none

// Thresholded Tanimoto or shared-over-present similarity of two feature vectors
// that stream in one element per transaction (value_a in tdata bits 31:0,
// value_b in 63:32, cutoff in 94:64, tlast on the final element). The front
// end takes one element per clock unless a pair ends while the queue is full,
// and keeps saturating shared and present counts; at the last element it
// pushes the pair's counts into a four-entry queue. The back end divides one
// pair at a time with a restoring divider that produces one quotient bit per
// clock. Short pairs are limited by the divider once the queue fills. An empty
// pair skips the division and goes straight to the finish state. The mode
// register sits at APB address 0 and is sampled when a pair completes.

module cutoff_tanimoto_similarity_unit
    import ctsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,

    // Feature stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // value_a, value_b, cutoff, zero fill
    input  wire logic                  s_tlast,  // last_feature

    // Score stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,  // score, zero fill
    output logic                       m_tuser   // empty_pair
);

    logic               mode_reg;
    logic               cfg_write;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    pair_t              q_push_data;
    pair_t              q_pop_data;
    logic [SCORE_W-1:0] score;

    // Mode register write and read-back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MODE);
    assign prdata    = (paddr[2] == REG_IDX_MODE) ? {{(APB_DATA_W - 1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OVER_PRESENT;
        end
        else if (cfg_write)
        begin
            mode_reg <= pwdata[0];
        end
    end

    ctsu_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .value_a      (s_tdata[VALUE_W-1:0]),
        .value_b      (s_tdata[2*VALUE_W-1:VALUE_W]),
        .cutoff       (s_tdata[2*VALUE_W+CUT_W-1:2*VALUE_W]),
        .last_feature (s_tlast),
        .mode         (mode_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    ctsu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    ctsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop_data (q_pop_data),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .score      (score),
        .empty_pair (m_tuser)
    );

    assign m_tdata = {{(OUT_DATA_W - SCORE_W){1'b0}}, score};

endmodule

`default_nettype wire

// ----- verif/tb_cutoff_tanimoto_similarity_unit.sv -----
module tb_cutoff_tanimoto_similarity_unit
    import ctsu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Register addresses and run constants.
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR  = {REG_IDX_MODE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {1'b1, 2'b00};
    localparam logic [CUT_W-1:0]      CUT_MAX    = '1;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 1_000_000;

    // Pair styles for the stream generator.
    localparam int PAIR_RANDOM      = 0;
    localparam int PAIR_ALL_SHARED  = 1;
    localparam int PAIR_MOSTLY_SHARED = 2;

    // One expected score transaction.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               empty;
    } pair_score_t;

    // Tracks the running counts of the current pair and the scores still owed.
    class similarity_scoreboard;
        logic             mode;
        logic [CNT_W-1:0] shared_cnt;
        logic [CNT_W-1:0] present_cnt;
        pair_score_t      owed_scores[$];
        int               mismatches;
        int               scored_pairs;
        int               empty_pairs;
        int               saturated_pairs;
        int               tanimoto_pairs;

        function new();
            mode = MODE_OVER_PRESENT;
            shared_cnt = '0;
            present_cnt = '0;
            mismatches = 0;
            scored_pairs = 0;
            empty_pairs = 0;
            saturated_pairs = 0;
            tanimoto_pairs = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function void log_mismatch(string what, longint unsigned want, longint unsigned got);
            if (mismatches < 10)
                $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
            mismatches++;
        endfunction

        // Counts one accepted feature; on the last one, forms the pair's score.
        function void note_feature(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                                   logic [CUT_W-1:0] cut, logic last);
            logic signed [DIFF_W-1:0] diff;
            logic [DIFF_W-1:0]        mag;
            logic [DEN_W-1:0]         den;
            logic [DVD_W-1:0]         quotient;
            pair_score_t              res;
            if (a != '0 || b != '0) begin
                diff = $signed({a[VALUE_W-1], a}) - $signed({b[VALUE_W-1], b});
                mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
                if (present_cnt < CNT_W'(MAX_FEATURES))
                    present_cnt = present_cnt + 1'b1;
                if (mag < DIFF_W'(cut) && shared_cnt < CNT_W'(MAX_FEATURES))
                    shared_cnt = shared_cnt + 1'b1;
            end
            if (!last)
                return;
            res.score = '0;
            res.empty = 1'b0;
            if (present_cnt == '0) begin
                res.empty = 1'b1;
                empty_pairs++;
            end else begin
                if (mode == MODE_TANIMOTO)
                    den = (DEN_W'(present_cnt) << 1) - DEN_W'(shared_cnt);
                else
                    den = DEN_W'(present_cnt);
                quotient = (DVD_W'(shared_cnt) << FRAC_W) / DVD_W'(den);
                res.score = (quotient > DVD_W'(1 << FRAC_W)) ? SCORE_W'(1 << FRAC_W)
                                                             : SCORE_W'(quotient);
            end
            if (present_cnt == CNT_W'(MAX_FEATURES))
                saturated_pairs++;
            if (mode == MODE_TANIMOTO)
                tanimoto_pairs++;
            owed_scores.push_back(res);
            shared_cnt = '0;
            present_cnt = '0;
        endfunction

        // Compares one accepted score transaction with the oldest owed score.
        function void check_score(logic [SCORE_W-1:0] score, logic empty);
            pair_score_t want;
            if (owed_scores.size() == 0) begin
                log_mismatch("score with no pair pending", 0, score);
                return;
            end
            want = owed_scores.pop_front();
            scored_pairs++;
            if (score !== want.score)
                log_mismatch("score", want.score, score);
            if (empty !== want.empty)
                log_mismatch("empty_pair", want.empty, empty);
        endfunction

        function int pending();
            return owed_scores.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // value_a, value_b, cutoff, zero fill
    logic                  s_tlast;   // last_feature
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // score, zero fill
    logic                  m_tuser;   // empty_pair

    similarity_scoreboard sb = new();
    bit hold_req = 1'b0;
    bit sender_steady = 1'b1;
    int burst_left = 0;
    int features_sent = 0;

    cutoff_tanimoto_similarity_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_cutoff_tanimoto_similarity_unit: done, errors");
        $finish;
    end

    // Score monitor: every accepted score transaction is checked.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_score(m_tdata[SCORE_W-1:0], m_tuser);
    end

    // Receiver: switches among stall patterns, and holds off once on request.
    initial
    begin
        int pattern;
        int pattern_left;
        int tick;
        pattern = 0;
        pattern_left = 0;
        tick = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (pattern_left == 0)
            begin
                pattern = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            tick++;
            case (pattern)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= ((tick % 5) < 2);
            endcase
        end
    end

    // Configuration write: setup phase, access phase until pready, then idle.
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == MODE_ADDR)
            sb.set_mode(data[0]);
        @(posedge clk);
    endtask

    // Configuration read of the mode register, checked against the predicted value.
    task automatic apb_check_mode();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== APB_DATA_W'(sb.mode))
            sb.log_mismatch("similarity_mode readback", sb.mode, prdata);
        @(posedge clk);
    endtask

    // Offers one feature transaction, with random gaps between bursts unless the sender is steady.
    task automatic send_feature(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                                input logic [CUT_W-1:0] cut, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  <= IN_DATA_W'({cut, b, a});
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_feature(a, b, cut, last);
        features_sent++;
    endtask

    // Sends one vector pair of the given length and style.
    task automatic send_pair(input int len, input int style);
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [CUT_W-1:0]   cut;
        logic [VALUE_W-1:0] mag;
        int                 kind;
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(0, 15);
            a = $urandom;
            b = $urandom;
            cut = CUT_W'($urandom);
            if (style == PAIR_ALL_SHARED || (style == PAIR_MOSTLY_SHARED && kind < 12))
            begin
                // Equal nonzero values with a positive cutoff always match.
                a[0] = 1'b1;
                b = a;
                if (cut == '0)
                    cut = CUT_MAX;
            end
            else if (style == PAIR_MOSTLY_SHARED)
            begin
                // Equal values with a zero cutoff are present but never shared.
                a[0] = 1'b1;
                b = a;
                cut = '0;
            end
            else
            begin
                case (kind)
                    0, 1: begin a = '0; b = '0; end
                    2:    a = '0;
                    3:    b = '0;
                    4, 5: ;
                    default:
                    begin
                        // Near values, with a cutoff around their distance.
                        mag = $urandom & ((VALUE_W'(1) << $urandom_range(0, 24)) - 1'b1);
                        b = $urandom_range(0, 1) ? a + mag : a - mag;
                        case ($urandom_range(0, 4))
                            0:       cut = CUT_W'(mag);
                            1:       cut = CUT_W'(mag) + 1'b1;
                            2:       cut = CUT_W'(mag) - 1'b1;
                            3:       cut = CUT_W'(mag) << 1;
                            default: cut = '0;
                        endcase
                    end
                endcase
            end
            send_feature(a, b, cut, i == len - 1);
        end
    endtask

    // Lowers the stream and waits until every owed score has come back.
    task automatic drain_scores();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Main sequence.
    initial
    begin
        int len;
        int sent;
        int errors;
        logic [APB_DATA_W-1:0] data;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part in the reset mode: empty pairs, cutoff edges, extreme values.
        apb_check_mode();
        sender_steady = 1'b1;
        send_feature('0, '0, CUT_MAX, 1'b1);
        send_feature('0, '0, '0, 1'b0);
        send_feature('0, '0, 31'd5, 1'b1);
        send_feature(32'h0001_0000, 32'h0000_0000, 31'h0001_0001, 1'b0);
        send_feature(32'h0002_0000, 32'h0001_0000, 31'h0001_0000, 1'b0);
        send_feature(32'h8000_0000, 32'h7FFF_FFFF, CUT_MAX, 1'b0);
        send_feature(32'h8000_0000, 32'h8000_0000, 31'd1, 1'b0);
        send_feature(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b0);
        send_feature(32'h0000_0000, 32'hFFFF_FFFF, 31'd2, 1'b0);
        send_feature('0, '0, CUT_MAX, 1'b1);
        send_feature(32'd5, 32'd5, 31'd1, 1'b1);
        send_feature(32'd1, 32'd0, '0, 1'b1);
        drain_scores();

        // Directed part in Tanimoto mode; the spare register index must be ignored.
        apb_write(MODE_ADDR, 32'hFFFF_FFFF);
        apb_write(SPARE_ADDR, 32'h0000_0000);
        apb_check_mode();
        send_feature(32'h5555_5555, 32'h5555_5554, 31'd2, 1'b0);
        send_feature(32'hAAAA_AAAA, 32'h5555_5555, CUT_MAX, 1'b0);
        send_feature(32'h1234_5678, 32'h0000_0000, 31'h0000_1000, 1'b1);
        send_feature(32'hFFFF_0000, 32'hFFFF_0001, 31'd2, 1'b0);
        send_feature(32'h0000_FFFF, 32'h0000_FFFF, 31'd1, 1'b1);
        send_feature('0, '0, '0, 1'b1);
        drain_scores();

        // Random phases, each with its own mode and sender behavior.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if ($urandom_range(0, 1) == 1)
                apb_write(SPARE_ADDR, $urandom);
            data = $urandom;
            data[0] = phase[0];
            apb_write(MODE_ADDR, data);
            apb_check_mode();
            sender_steady = ($urandom_range(0, 3) == 0);
            if (phase == 1)
                hold_req = 1'b1;
            // A short pair that mixes shared and unshared features.
            if (phase == 2)
                send_pair($urandom_range(20, 60), PAIR_MOSTLY_SHARED);
            // One pair long enough to saturate both counts.
            if (phase == 5)
                send_pair($urandom_range(1030, 1060), PAIR_ALL_SHARED);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                    6, 7, 8:          len = $urandom_range(5, 12);
                    default:          len = $urandom_range(13, 60);
                endcase
                send_pair(len, PAIR_RANDOM);
                sent += len;
            end
            drain_scores();
        end

        errors = sb.mismatches + sb.pending();
        if (sb.pending() != 0)
            $display("%0d expected scores never arrived", sb.pending());
        $display("Ran %0d feature transactions over %0d random phases in both modes.",
                 features_sent, NUM_PHASES);
        $display("Checked %0d scores: %0d empty pairs, %0d saturated, %0d in Tanimoto mode.",
                 sb.scored_pairs, sb.empty_pairs, sb.saturated_pairs, sb.tanimoto_pairs);
        if (errors == 0)
            $display("tb_cutoff_tanimoto_similarity_unit: done, clean");
        else
            $display("tb_cutoff_tanimoto_similarity_unit: done, errors");
        $finish;
    end

endmodule
